// ===== rtl/core/priority_ready_queue_scheduler_aging_defines.svh =====
// ----------------------------------------------------------------------------
// Scheduler assertion macros
// Shared helpers for the concurrent checks of the ready-queue scheduler.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_READY_QUEUE_SCHEDULER_AGING_DEFINES_SVH
`define PRIORITY_READY_QUEUE_SCHEDULER_AGING_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define PRQS_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define PRQS_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/prqs_pkg.sv =====
// ----------------------------------------------------------------------------
// Scheduler package
// Codes, field widths and the sequencer state type of the ready-queue scheduler.
// ----------------------------------------------------------------------------
package prqs_pkg;

   localparam int PID_W  = 4;
   localparam int PREQ_W = 4;
   localparam int OP_W   = 2;
   localparam int WAIT_W = 8;
   localparam int ST_W   = 2;

   localparam logic [OP_W-1:0] OP_MAKE_READY = 2'd0;
   localparam logic [OP_W-1:0] OP_YIELD      = 2'd1;
   localparam logic [OP_W-1:0] OP_BLOCK      = 2'd2;
   localparam logic [OP_W-1:0] OP_UNUSED     = 2'd3;

   localparam logic [ST_W-1:0] ST_NONE  = 2'd0;
   localparam logic [ST_W-1:0] ST_READY = 2'd1;
   localparam logic [ST_W-1:0] ST_RUN   = 2'd2;

   // Byte address of the aging threshold register.
   localparam logic [1:0] ADDR_AGING_THR = 2'd0;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_MOD   = 7'b0000010,
      S_AGE   = 7'b0000100,
      S_PICK  = 7'b0001000,
      S_SLOT  = 7'b0010000,
      S_RUNWR = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

endpackage

// ===== rtl/core/prqs_pmem.sv =====
// ----------------------------------------------------------------------------
// Process table memory
// Synchronous single-read single-write memory whose entries read as zero until
// first written.
// ----------------------------------------------------------------------------
module prqs_pmem #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 13
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [WIDTH-1:0] rdata_ff;
   logic             rvalid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   // An entry that was never written reads as zero through its valid bit.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rvalid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rvalid_ff ? rdata_ff : '0;

endmodule

// ===== rtl/core/priority_ready_queue_scheduler_aging.sv =====
// ----------------------------------------------------------------------------
// Priority ready-queue scheduler with aging
// Per-level FIFO ready queues held in a slot memory, and a process table memory
// holding status, priority and wait count for every process.
// ----------------------------------------------------------------------------
// Sequence: make_ready of a nonzero pid passes S_MOD and S_DONE; yield and block
// pass S_MOD unless the idle process runs, the S_AGE walk, the S_PICK scan, then
// S_SLOT and S_RUNWR when a process is found, and S_DONE. Throughput: one
// transaction at a time; the next is accepted once the result is registered. The
// aging walk (one table entry a cycle) and level scan (one level a cycle) dominate a yield or block.
// Reset: synchronous; empty queues, all processes not ready, the idle process
// running, aging threshold 10. No clearing pass is needed.
`include "priority_ready_queue_scheduler_aging_defines.svh"

module priority_ready_queue_scheduler_aging #(
   parameter int NUM_PROCS  = 16,
   parameter int NUM_LEVELS = 8
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [3:0] pid, [7:4] priority_req
   input  logic [1:0]  req_tuser,   // [1:0] op
   // Response channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [3:0] current_pid, [4] found, [5] switched, zero fill
   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int PW = $clog2(NUM_PROCS);
   localparam int LW = $clog2(NUM_LEVELS);
   localparam int EW = prqs_pkg::ST_W + LW + prqs_pkg::WAIT_W;
   localparam int SLOTS = NUM_LEVELS * (2 ** PW);

   // Next slot index with wrap at NUM_PROCS.
   function automatic logic [PW-1:0] nxt(input logic [PW-1:0] t);
      nxt = (int'(t) == NUM_PROCS - 1) ? '0 : PW'(int'(t) + 1);
   endfunction

   // ---------------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------------
   prqs_pkg::state_type state_ff, state_in;
   logic [prqs_pkg::OP_W-1:0]   op_ff, op_in;
   logic [prqs_pkg::PID_W-1:0]  pid_ff, pid_in;
   logic [LW-1:0]               plv_ff, plv_in;
   logic [prqs_pkg::PID_W-1:0]  old_ff, old_in;
   logic [prqs_pkg::PID_W-1:0]  run_ff, run_in;
   logic                        found_ff, found_in;
   logic [PW-1:0]               age_ff, age_in;
   logic [LW-1:0]               lv_ff, lv_in;
   logic [7:0]                  thr_ff, thr_in;
   logic [PW-1:0]               head_ff [NUM_LEVELS];
   logic [PW-1:0]               head_in [NUM_LEVELS];
   logic [PW-1:0]               tail_ff [NUM_LEVELS];
   logic [PW-1:0]               tail_in [NUM_LEVELS];
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [7:0]                  rsp_data_ff, rsp_data_in;

   // Slot memory: one row of 2**PW slots for each level, NUM_PROCS of them in use.
   logic [prqs_pkg::PID_W-1:0]  slot_mem [SLOTS];
   logic [prqs_pkg::PID_W-1:0]  slot_q_ff;
   logic                        slot_we, slot_re;
   logic [LW+PW-1:0]            slot_waddr, slot_raddr;
   logic [prqs_pkg::PID_W-1:0]  slot_wdata;

   // Process table memory ports.
   logic          pm_re, pm_we;
   logic [PW-1:0] pm_raddr, pm_waddr;
   logic [EW-1:0] pm_rdata, pm_wdata;

   logic [prqs_pkg::ST_W-1:0]   ent_st;
   logic [LW-1:0]               ent_pr;
   logic [prqs_pkg::WAIT_W-1:0] ent_wt;
   logic [prqs_pkg::WAIT_W:0]   wt_inc;
   logic [LW-1:0]               enq_lv;
   logic [prqs_pkg::PID_W-1:0]  enq_pid;
   logic                        enq_ok, load_rsp, sw_in, req_hs;
   logic [prqs_pkg::PID_W-1:0]  req_pid;
   logic [prqs_pkg::PREQ_W-1:0] req_preq;

   assign req_pid  = req_tdata[3:0];
   assign req_preq = req_tdata[7:4];
   assign req_hs   = req_tvalid && req_tready;
   assign req_tready = (state_ff == prqs_pkg::S_IDLE);

   assign {ent_st, ent_pr, ent_wt} = pm_rdata;
   assign wt_inc = {1'b0, ent_wt} + 9'd1;

   prqs_pmem #(.DEPTH(NUM_PROCS), .WIDTH(EW)) u_pmem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (pm_re),
      .rd_addr (pm_raddr),
      .rd_data (pm_rdata),
      .wr_en   (pm_we),
      .wr_addr (pm_waddr),
      .wr_data (pm_wdata)
   );

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_waddr] <= slot_wdata;
      end
      if (slot_re) begin
         slot_q_ff <= slot_mem[slot_raddr];
      end
   end

   // ---------------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      pid_in       = pid_ff;
      plv_in       = plv_ff;
      old_in       = old_ff;
      run_in       = run_ff;
      found_in     = found_ff;
      age_in       = age_ff;
      lv_in        = lv_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      pm_re        = 1'b0;
      pm_raddr     = '0;
      pm_we        = 1'b0;
      pm_waddr     = '0;
      pm_wdata     = '0;
      slot_we      = 1'b0;
      slot_waddr   = '0;
      slot_wdata   = '0;
      slot_re      = 1'b0;
      slot_raddr   = '0;
      enq_lv       = '0;
      enq_pid      = '0;
      enq_ok       = 1'b0;
      load_rsp     = 1'b0;
      sw_in        = 1'b0;

      unique case (state_ff)
         prqs_pkg::S_IDLE: begin
            if (req_hs) begin
               op_in    = req_tuser;
               pid_in   = req_pid;
               old_in   = run_ff;
               found_in = 1'b0;
               plv_in   = (int'(req_preq) >= NUM_LEVELS) ? LW'(NUM_LEVELS - 1) : LW'(req_preq);
               age_in   = '0;
               state_in = prqs_pkg::S_DONE;
               if (req_tuser == prqs_pkg::OP_MAKE_READY) begin
                  if (req_pid != '0 && int'(req_pid) < NUM_PROCS) begin
                     pm_re    = 1'b1;
                     pm_raddr = PW'(req_pid);
                     state_in = prqs_pkg::S_MOD;
                  end
               end else if (req_tuser == prqs_pkg::OP_YIELD ||
                            req_tuser == prqs_pkg::OP_BLOCK) begin
                  pm_re = 1'b1;
                  if (run_ff != '0) begin
                     pm_raddr = PW'(run_ff);
                     state_in = prqs_pkg::S_MOD;
                  end else begin
                     pm_raddr = '0;
                     state_in = prqs_pkg::S_AGE;
                  end
               end
            end
         end

         prqs_pkg::S_MOD: begin
            pm_we = 1'b1;
            if (op_ff == prqs_pkg::OP_MAKE_READY) begin
               pm_waddr = PW'(pid_ff);
               pm_wdata = {prqs_pkg::ST_READY, plv_ff, ent_wt};
               enq_lv   = plv_ff;
               enq_pid  = pid_ff;
               enq_ok   = 1'b1;
               state_in = prqs_pkg::S_DONE;
            end else begin
               pm_waddr = PW'(old_ff);
               enq_lv   = ent_pr;
               enq_pid  = old_ff;
               if (op_ff == prqs_pkg::OP_YIELD) begin
                  pm_wdata = {prqs_pkg::ST_READY, ent_pr, ent_wt};
                  enq_ok   = 1'b1;
               end else begin
                  pm_wdata = {prqs_pkg::ST_NONE, ent_pr, ent_wt};
               end
               pm_re    = 1'b1;
               pm_raddr = '0;
               age_in   = '0;
               state_in = prqs_pkg::S_AGE;
            end
            // A full level drops the new entry.
            if (enq_ok && nxt(tail_ff[enq_lv]) != head_ff[enq_lv]) begin
               slot_we          = 1'b1;
               slot_waddr       = {enq_lv, tail_ff[enq_lv]};
               slot_wdata       = enq_pid;
               tail_in[enq_lv]  = nxt(tail_ff[enq_lv]);
            end
         end

         prqs_pkg::S_AGE: begin
            // Entry age_ff is on the read port; the next one is fetched meanwhile.
            if (ent_st == prqs_pkg::ST_READY) begin
               pm_we    = 1'b1;
               pm_waddr = age_ff;
               if (wt_inc >= {1'b0, thr_ff}) begin
                  pm_wdata = {ent_st,
                              (int'(ent_pr) + 1 < NUM_LEVELS) ? LW'(int'(ent_pr) + 1) : ent_pr,
                              8'd0};
               end else begin
                  pm_wdata = {ent_st, ent_pr, wt_inc[7:0]};
               end
            end
            if (int'(age_ff) == NUM_PROCS - 1) begin
               lv_in    = LW'(NUM_LEVELS - 1);
               state_in = prqs_pkg::S_PICK;
            end else begin
               pm_re    = 1'b1;
               pm_raddr = PW'(int'(age_ff) + 1);
               age_in   = PW'(int'(age_ff) + 1);
            end
         end

         prqs_pkg::S_PICK: begin
            if (head_ff[lv_ff] != tail_ff[lv_ff]) begin
               slot_re         = 1'b1;
               slot_raddr      = {lv_ff, head_ff[lv_ff]};
               head_in[lv_ff]  = nxt(head_ff[lv_ff]);
               state_in        = prqs_pkg::S_SLOT;
            end else if (lv_ff == '0) begin
               if (op_ff == prqs_pkg::OP_BLOCK) begin
                  run_in = '0;
               end
               state_in = prqs_pkg::S_DONE;
            end else begin
               lv_in = lv_ff - 1'b1;
            end
         end

         prqs_pkg::S_SLOT: begin
            pm_re    = 1'b1;
            pm_raddr = PW'(slot_q_ff);
            run_in   = slot_q_ff;
            found_in = 1'b1;
            state_in = prqs_pkg::S_RUNWR;
         end

         prqs_pkg::S_RUNWR: begin
            pm_we    = 1'b1;
            pm_waddr = PW'(run_ff);
            pm_wdata = {prqs_pkg::ST_RUN, ent_pr, 8'd0};
            state_in = prqs_pkg::S_DONE;
         end

         prqs_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               load_rsp     = 1'b1;
               sw_in        = (op_ff == prqs_pkg::OP_YIELD || op_ff == prqs_pkg::OP_BLOCK) &&
                              (run_ff != old_ff);
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'b00, sw_in, found_ff, run_ff};
               state_in     = prqs_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = prqs_pkg::S_IDLE;
         end
      endcase
   end

   // Configuration register: the aging threshold sits at byte address zero.
   always_comb begin
      thr_in = thr_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
          csr_paddr == prqs_pkg::ADDR_AGING_THR) begin
         thr_in = csr_pwdata[7:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == prqs_pkg::ADDR_AGING_THR) ? {24'd0, thr_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= prqs_pkg::S_IDLE;
         run_ff       <= '0;
         thr_ff       <= 8'd10;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_LEVELS; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         run_ff       <= run_in;
         thr_ff       <= thr_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      pid_ff      <= pid_in;
      plv_ff      <= plv_in;
      old_ff      <= old_in;
      found_ff    <= found_in;
      age_ff      <= age_in;
      lv_ff       <= lv_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ---------------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------------
   `PRQS_ASSERT_NXT(a_accept_busy, req_hs, state_ff != prqs_pkg::S_IDLE, "accepted while busy")
   `PRQS_ASSERT_IMP(a_switch_diff, load_rsp && sw_in, run_ff != old_ff, "bad switch flag")
   `PRQS_ASSERT_IMP(a_head_range, state_ff == prqs_pkg::S_PICK, int'(head_ff[lv_ff]) < NUM_PROCS, "head out of range")

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ready-queue scheduler testbench
// Drives make_ready, yield and block transactions with random gaps and stalls
// on both channels. A behavioural scheduler model predicts each response, and
// a scoreboard compares the responses field by field in order.
// ----------------------------------------------------------------------------

typedef struct packed {
   logic [3:0] pid;
   logic       found;
   logic       switched;
} sched_rsp_type;

// Expected responses wait here in order; the scheduler model fills the queue.
class sched_scoreboard_type;
   sched_rsp_type pending[$];
   int            errors = 0;

   // Ready-queue state of the model.
   logic [7:0] threshold;
   logic [3:0] slots[8][16];
   logic [3:0] heads[8];
   logic [3:0] tails[8];
   logic [1:0] status[16];
   logic [2:0] prio[16];
   logic [7:0] waits[16];
   logic [3:0] running;

   function void clear();
      threshold = 8'd10;
      running = 4'd0;
      for (int l = 0; l < 8; l++) begin
         heads[l] = 4'd0;
         tails[l] = 4'd0;
         for (int p = 0; p < 16; p++) slots[l][p] = 4'd0;
      end
      for (int p = 0; p < 16; p++) begin
         status[p] = prqs_pkg::ST_NONE;
         prio[p] = 3'd0;
         waits[p] = 8'd0;
      end
   endfunction

   function void push_ready(logic [3:0] p);
      logic [2:0] lv;
      lv = prio[p];
      if (p == 4'd0) return;
      // A full level drops the entry: one slot is always kept free.
      if (tails[lv] + 4'd1 == heads[lv]) return;
      slots[lv][tails[lv]] = p;
      tails[lv] = tails[lv] + 4'd1;
   endfunction

   // Notes an accepted request and predicts its response.
   function void note_request(logic [1:0] op, logic [3:0] pid, logic [3:0] preq);
      logic [3:0] prev;
      logic [3:0] pick;
      logic [8:0] w;
      logic       hit;
      sched_rsp_type r;
      prev = running;
      hit = 1'b0;
      r.found = 1'b0;
      if (op == prqs_pkg::OP_MAKE_READY) begin
         if (pid != 4'd0) begin
            prio[pid] = (preq > 4'd7) ? 3'd7 : preq[2:0];
            status[pid] = prqs_pkg::ST_READY;
            push_ready(pid);
         end
      end else if (op == prqs_pkg::OP_YIELD || op == prqs_pkg::OP_BLOCK) begin
         if (prev != 4'd0) begin
            if (op == prqs_pkg::OP_YIELD) begin
               status[prev] = prqs_pkg::ST_READY;
               push_ready(prev);
            end else begin
               status[prev] = prqs_pkg::ST_NONE;
            end
         end
         // Aging raises the priority only; queue entries stay where they are.
         for (int p = 0; p < 16; p++) begin
            if (status[p] == prqs_pkg::ST_READY) begin
               w = waits[p] + 9'd1;
               if (w >= threshold) begin
                  if (prio[p] != 3'd7) prio[p] = prio[p] + 3'd1;
                  w = 9'd0;
               end
               waits[p] = w[7:0];
            end
         end
         for (int l = 7; l >= 0 && !hit; l--) begin
            if (heads[l] != tails[l]) begin
               pick = slots[l][heads[l]];
               heads[l] = heads[l] + 4'd1;
               hit = 1'b1;
            end
         end
         if (hit) begin
            status[pick] = prqs_pkg::ST_RUN;
            waits[pick] = 8'd0;
            running = pick;
         end else if (op == prqs_pkg::OP_BLOCK) begin
            running = 4'd0;
         end
         r.found = hit;
      end
      r.pid = running;
      r.switched = (op == prqs_pkg::OP_YIELD || op == prqs_pkg::OP_BLOCK) && running != prev;
      pending.push_back(r);
   endfunction

   function void check_response(logic [7:0] data);
      sched_rsp_type e;
      if (pending.size() == 0) begin
         $display("%0t: unexpected response %h", $time, data);
         errors++;
         return;
      end
      e = pending.pop_front();
      if (data[3:0] !== e.pid) begin
         $display("%0t: current_pid expected %0d actual %0d", $time, e.pid, data[3:0]);
         errors++;
      end
      if (data[4] !== e.found) begin
         $display("%0t: found expected %0d actual %0d", $time, e.found, data[4]);
         errors++;
      end
      if (data[5] !== e.switched) begin
         $display("%0t: switched expected %0d actual %0d", $time, e.switched, data[5]);
         errors++;
      end
      if (data[7:6] !== 2'b00) begin
         $display("%0t: fill bits expected 0 actual %b", $time, data[7:6]);
         errors++;
      end
   endfunction
endclass

module testbench;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic [1:0]  req_tuser = 2'd0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [1:0]  csr_paddr = 2'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   sched_scoreboard_type board = new();

   // Set by the stimulus: hold-off of the receiver, and the gap-free tail.
   bit          hold_rsp = 1'b0;
   bit          no_gaps = 1'b0;
   int unsigned cycles = 0;

   localparam int unsigned CYCLE_LIMIT = 600000;

   priority_ready_queue_scheduler_aging uut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Watchdog: stops a run that hangs and reports it as failed.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Responses are checked at the rising edge at which the transaction completes.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_response(rsp_tdata);
   end

   // Receiver: random stall bursts, a long hold-off on request, none at the end.
   initial begin : receiver
      int n;
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            while (hold_rsp) @(negedge clock);
         end else if (!no_gaps && $urandom_range(3) == 0) begin
            rsp_tready <= 1'b0;
            n = $urandom_range(7, 1);
            repeat (n) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
            n = $urandom_range(12, 1);
            repeat (n) @(negedge clock);
         end
      end
   end

   // Sends one request transaction and waits for its acceptance.
   task automatic send_request(logic [1:0] op, logic [3:0] pid, logic [3:0] preq);
      if (!no_gaps && $urandom_range(4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(7, 1)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {preq, pid};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_request(op, pid, preq);
      @(negedge clock);
   endtask

   // Register write over the APB-style port: setup then access phase.
   task automatic write_threshold(logic [7:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= prqs_pkg::ADDR_AGING_THR;
      csr_pwdata <= {24'd0, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      board.threshold = value;
   endtask

   // Waits for every expected response, then lets the block settle.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   // Mostly wake-ups and yields of live processes, with some blocks and noise.
   task automatic random_phase(int count);
      logic [1:0] op;
      int         r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         if (r < 45) op = prqs_pkg::OP_MAKE_READY;
         else if (r < 75) op = prqs_pkg::OP_YIELD;
         else if (r < 96) op = prqs_pkg::OP_BLOCK;
         else op = prqs_pkg::OP_UNUSED;
         send_request(op, 4'($urandom), 4'($urandom));
      end
   endtask

   initial begin : stimulus
      board.clear();
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: idle scheduling, idle process and range extremes, unused op.
      send_request(prqs_pkg::OP_YIELD, 4'd0, 4'd0);
      send_request(prqs_pkg::OP_BLOCK, 4'd0, 4'd0);
      send_request(prqs_pkg::OP_MAKE_READY, 4'd0, 4'd15);
      send_request(prqs_pkg::OP_MAKE_READY, 4'd15, 4'd15);
      send_request(prqs_pkg::OP_MAKE_READY, 4'd1, 4'd0);
      send_request(prqs_pkg::OP_UNUSED, 4'd15, 4'd15);
      send_request(prqs_pkg::OP_YIELD, 4'd0, 4'd0);
      send_request(prqs_pkg::OP_YIELD, 4'd0, 4'd0);
      send_request(prqs_pkg::OP_MAKE_READY, 4'd1, 4'd7);
      send_request(prqs_pkg::OP_MAKE_READY, 4'd1, 4'd8);
      send_request(prqs_pkg::OP_YIELD, 4'd0, 4'd0);
      send_request(prqs_pkg::OP_BLOCK, 4'd0, 4'd0);
      send_request(prqs_pkg::OP_BLOCK, 4'd0, 4'd0);
      send_request(prqs_pkg::OP_BLOCK, 4'd0, 4'd0);
      send_request(prqs_pkg::OP_BLOCK, 4'd0, 4'd0);
      // Fill one level past its capacity with repeated wake-ups.
      for (int p = 0; p < 18; p++) begin
         send_request(prqs_pkg::OP_MAKE_READY, 4'(p % 15 + 1), 4'd3);
      end
      drain();

      // Threshold extremes, then a few mid-range settings.
      write_threshold(8'd1);
      random_phase(250);
      drain();
      write_threshold(8'd255);
      random_phase(250);
      drain();
      write_threshold(8'd0);
      random_phase(150);
      drain();

      // Receiver holds off long while the sender keeps offering transactions.
      write_threshold(8'd3);
      hold_rsp = 1'b1;
      fork
         random_phase(20);
         begin
            repeat (300) @(negedge clock);
            hold_rsp = 1'b0;
         end
      join
      random_phase(250);
      drain();

      write_threshold(8'($urandom_range(40, 2)));
      random_phase(200);
      no_gaps = 1'b1;
      random_phase(100);
      drain();

      if (board.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== priority_ready_queue_scheduler_aging.f =====
+incdir+rtl/core
rtl/core/prqs_pkg.sv
rtl/core/prqs_pmem.sv
rtl/core/priority_ready_queue_scheduler_aging.sv
sim/testbench.sv
